>>> rtl/scc_pkg.sv
package scc_pkg;

    localparam int VERTICES_DEFAULT = 32;
    localparam int ROW_INDEX_W      = 5;
    localparam int ROW_BITS_W       = 32;
    localparam int CFG_W            = 6;
    localparam int OUT_ID_W         = 5;
    localparam logic [CFG_W-1:0] VERTEX_COUNT_RESET = 6'd32;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_PASS_START,
        ST_SEED,
        ST_SCAN,
        ST_EMIT,
        ST_CLEAR
    } scc_state_t;

    typedef struct packed {
        logic load_row;
        logic begin_pass;
        logic seed;
        logic scan;
        logic emit;
        logic clear_step;
        logic next_seed;
    } scc_cmd_t;

    typedef struct packed {
        logic seed_done;
        logic seed_ok;
        logic stack_empty;
        logic pass_two;
        logic emit_done;
        logic clear_done;
    } scc_status_t;

endpackage

>>> rtl/scc_ctrl.sv
module scc_ctrl
    import scc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        last_row,
    input  scc_status_t status,
    output scc_cmd_t    cmd,
    output logic        busy
);

    scc_state_t state_reg;
    scc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            ST_LOAD:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load_row = 1'b1;
                    if (last_row)
                    begin
                        state_next = ST_PASS_START;
                    end
                end
            end
            ST_PASS_START:
            begin
                cmd.begin_pass = 1'b1;
                state_next     = ST_SEED;
            end
            ST_SEED:
            begin
                if (status.seed_done)
                begin
                    if (status.pass_two)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_PASS_START;
                    end
                end
                else if (status.seed_ok)
                begin
                    cmd.seed   = 1'b1;
                    state_next = ST_SCAN;
                end
                else
                begin
                    cmd.next_seed = 1'b1;
                end
            end
            ST_SCAN:
            begin
                if (status.stack_empty)
                begin
                    cmd.next_seed = 1'b1;
                    state_next    = ST_SEED;
                end
                else
                begin
                    cmd.scan = 1'b1;
                end
            end
            ST_EMIT:
            begin
                cmd.emit = 1'b1;
                if (status.emit_done)
                begin
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_done)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

>>> rtl/scc_datapath.sv
module scc_datapath
    import scc_pkg::*;
#(
    parameter int VERTICES = VERTICES_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  scc_cmd_t               cmd,
    output scc_status_t            status,
    input  logic [CFG_W-1:0]       cfg_data,
    input  logic                   cfg_we,
    input  logic [ROW_INDEX_W-1:0] row_index,
    input  logic [ROW_BITS_W-1:0]  row_bits,
    output logic                   result_valid,
    output logic [OUT_ID_W-1:0]    vertex_id,
    output logic [OUT_ID_W-1:0]    component_id,
    output logic                   component_end,
    output logic                   run_end
);

    localparam int VW = (VERTICES > 1) ? $clog2(VERTICES) : 1;
    localparam int CW = $clog2(VERTICES + 1);

    logic [VERTICES-1:0]   adj_reg [VERTICES];
    logic [VERTICES-1:0]   visited_reg;
    logic [VW-1:0]         finish_reg [VERTICES];
    logic [VW-1:0]         order_reg [VERTICES];
    logic [VERTICES-1:0]   comp_end_reg;
    logic [OUT_ID_W-1:0]   comp_of_reg [VERTICES];
    logic [VW-1:0]         stk_v_reg [VERTICES];
    logic [CW-1:0]         stk_k_reg [VERTICES];
    logic [CW-1:0]         depth_reg;
    logic [CFG_W-1:0]      vcount_reg;
    logic                  pass_reg;
    logic [CW-1:0]         seed_reg;
    logic [CW-1:0]         fcount_reg;
    logic [CW-1:0]         ocount_reg;
    logic [OUT_ID_W-1:0]   comp_reg;
    logic [CW-1:0]         emit_reg;
    logic [CW-1:0]         clear_reg;

    logic [CW-1:0]         n_eff;
    logic [VERTICES-1:0]   nmask;
    logic [VW-1:0]         seed_v;
    logic [VW-1:0]         top_v;
    logic [CW-1:0]         top_k;
    logic                  cand_bit;
    logic [VW-1:0]         k_idx;

    always_comb
    begin
        if (vcount_reg < 6'd2)
        begin
            n_eff = CW'(2);
        end
        else if (int'(vcount_reg) > VERTICES)
        begin
            n_eff = CW'(VERTICES);
        end
        else
        begin
            n_eff = CW'(vcount_reg);
        end
        for (int i = 0; i < VERTICES; i++)
        begin
            nmask[i] = (i < n_eff);
        end
        if (pass_reg)
        begin
            seed_v = finish_reg[VW'(seed_reg - CW'(1))];
        end
        else
        begin
            seed_v = VW'(seed_reg);
        end
        top_v = stk_v_reg[VW'(depth_reg - CW'(1))];
        top_k = stk_k_reg[VW'(depth_reg - CW'(1))];
        k_idx = VW'(top_k);
        if (pass_reg)
        begin
            cand_bit = adj_reg[top_v][k_idx];
        end
        else
        begin
            cand_bit = adj_reg[k_idx][top_v];
        end
        cand_bit = cand_bit && !visited_reg[k_idx];
    end

    assign status.seed_done   = pass_reg ? (seed_reg == '0) : (seed_reg >= n_eff);
    assign status.seed_ok     = !visited_reg[seed_v] &&
                                (VW'(seed_v) < n_eff);
    assign status.stack_empty = (depth_reg == '0);
    assign status.pass_two    = pass_reg;
    assign status.emit_done   = (emit_reg + CW'(1) >= ocount_reg);
    assign status.clear_done  = (clear_reg == CW'(VERTICES - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg   <= VERTEX_COUNT_RESET;
            pass_reg     <= 1'b1;
            visited_reg  <= '0;
            depth_reg    <= '0;
            seed_reg     <= '0;
            fcount_reg   <= '0;
            ocount_reg   <= '0;
            comp_reg     <= '0;
            emit_reg     <= '0;
            clear_reg    <= '0;
            result_valid <= 1'b0;
            for (int i = 0; i < VERTICES; i++)
            begin
                adj_reg[i] <= '0;
            end
        end
        else
        begin
            result_valid <= 1'b0;
            if (cfg_we)
            begin
                vcount_reg <= cfg_data;
            end
            if (cmd.load_row && (int'(row_index) < VERTICES))
            begin
                adj_reg[VW'(row_index)] <= VERTICES'(row_bits);
            end
            if (cmd.begin_pass)
            begin
                pass_reg    <= !pass_reg;
                visited_reg <= '0;
                comp_reg    <= '0;
                ocount_reg  <= '0;
                emit_reg    <= '0;
                clear_reg   <= '0;
                if (pass_reg)
                begin
                    seed_reg   <= '0;
                    fcount_reg <= '0;
                    for (int i = 0; i < VERTICES; i++)
                    begin
                        adj_reg[i] <= adj_reg[i] & nmask;
                    end
                end
                else
                begin
                    seed_reg <= fcount_reg;
                end
            end
            if (cmd.next_seed)
            begin
                if (pass_reg)
                begin
                    seed_reg <= seed_reg - CW'(1);
                end
                else
                begin
                    seed_reg <= seed_reg + CW'(1);
                end
            end
            if (cmd.seed)
            begin
                visited_reg[seed_v] <= 1'b1;
                stk_v_reg[0]        <= seed_v;
                stk_k_reg[0]        <= '0;
                depth_reg           <= CW'(1);
            end
            if (cmd.scan)
            begin
                if (top_k < n_eff)
                begin
                    stk_k_reg[VW'(depth_reg - CW'(1))] <= top_k + CW'(1);
                    if (cand_bit)
                    begin
                        visited_reg[k_idx]      <= 1'b1;
                        stk_v_reg[VW'(depth_reg)] <= k_idx;
                        stk_k_reg[VW'(depth_reg)] <= '0;
                        depth_reg               <= depth_reg + CW'(1);
                    end
                end
                else
                begin
                    depth_reg <= depth_reg - CW'(1);
                    if (pass_reg)
                    begin
                        order_reg[VW'(ocount_reg)]   <= top_v;
                        comp_of_reg[VW'(ocount_reg)] <= comp_reg;
                        comp_end_reg[VW'(ocount_reg)] <= (depth_reg == CW'(1));
                        ocount_reg <= ocount_reg + CW'(1);
                        if (depth_reg == CW'(1))
                        begin
                            comp_reg <= comp_reg + OUT_ID_W'(1);
                        end
                    end
                    else
                    begin
                        finish_reg[VW'(fcount_reg)] <= top_v;
                        fcount_reg <= fcount_reg + CW'(1);
                    end
                end
            end
            if (cmd.emit)
            begin
                result_valid  <= 1'b1;
                vertex_id     <= OUT_ID_W'(order_reg[VW'(emit_reg)]);
                component_id  <= comp_of_reg[VW'(emit_reg)];
                component_end <= comp_end_reg[VW'(emit_reg)];
                run_end       <= status.emit_done;
                emit_reg      <= emit_reg + CW'(1);
            end
            if (cmd.clear_step)
            begin
                adj_reg[VW'(clear_reg)] <= '0;
                clear_reg <= clear_reg + CW'(1);
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= CW'(VERTICES))
        else $error("walk stack overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && run_end |=> !result_valid)
        else $error("result after run end");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.seed |=> depth_reg == CW'(1))
        else $error("seed did not start walk");

endmodule

>>> rtl/strongly_connected_components_unit.sv
// Rows load one per cycle while busy is low, and a row that is not last leaves busy low.
// After the last row, two depth-first passes over the N vertices in use test one adjacency bit
// per cycle while scanning, with seeding and backtracking steps in between.
// Then N results stream out one per cycle and a sweep clears all VERTICES rows,
// after which busy drops again. The receiver cannot stall results.
// Asynchronous active-low reset clears all rows and sets vertex_count to 32.
module strongly_connected_components_unit
    import scc_pkg::*;
#(
    parameter int VERTICES = VERTICES_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [ROW_INDEX_W-1:0] row_index,
    input  logic [ROW_BITS_W-1:0]  row_bits,
    input  logic                   last_row,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_W-1:0]       cfg_data,
    output logic                   result_valid,
    output logic [OUT_ID_W-1:0]    vertex_id,
    output logic [OUT_ID_W-1:0]    component_id,
    output logic                   component_end,
    output logic                   run_end
);

    scc_cmd_t    cmd;
    scc_status_t status;

    assign cfg_ready = !busy;

    scc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .last_row (last_row),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy)
    );

    scc_datapath #(
        .VERTICES (VERTICES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_data      (cfg_data),
        .cfg_we        (cfg_valid & cfg_ready),
        .row_index     (row_index),
        .row_bits      (row_bits),
        .result_valid  (result_valid),
        .vertex_id     (vertex_id),
        .component_id  (component_id),
        .component_end (component_end),
        .run_end       (run_end)
    );

endmodule
